/* hw/rtl/mudp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the MoldUDP64 add order stock filter.
// No dependencies; the top level, csr, parser and fifo use it by scoped names.
package mudp_pkg;

   // Fixed protocol layout
   localparam int HeaderBytes  = 20;
   localparam int StockOffset  = 24;
   localparam int StockBytes   = 8;
   localparam logic [7:0]  ADD_ORDER_TYPE = 8'h41;
   localparam logic [15:0] END_OF_SESSION = 16'hFFFF;
   localparam logic [63:0] SPACES8        = 64'h2020_2020_2020_2020;

   // Body offset is only compared below StockOffset + StockBytes, so it saturates
   localparam int OffWidth = 6;
   localparam logic [OffWidth-1:0] OFF_SAT = '1;

   // Result kinds
   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_FILTER_COUNT,
      REG_IGNORE_FILTER,
      REG_STOCK_A,
      REG_STOCK_B,
      REG_STOCK_C,
      REG_STOCK_D,
      REG_STOCK_E,
      REG_STOCK_F
   } reg_index_type;

   // Parser phases
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_BODY,
      PH_IDLE
   } phase_type;

   // Scalar filter controls
   typedef struct packed {
      logic [2:0] filter_count;
      logic       ignore_filter;
   } ctrl_type;

   // One result item
   typedef struct packed {
      logic        kind;
      logic [15:0] message_index;
      logic [63:0] stock_seen;
      logic        hit;
      logic        packet_hit;
      logic [31:0] packets_seen;
      logic [31:0] packets_hit;
      logic        last;
   } rsp_item_type;

   // Results produced by one accepted byte, verdict first
   typedef struct packed {
      logic         vrd_valid;
      rsp_item_type vrd;
      logic         sum_valid;
      rsp_item_type sum;
   } push_type;

endpackage

/* hw/rtl/mudp_req_if.sv */
`timescale 1ns / 1ps
// Input byte channel: valid/ready handshake with one payload byte and packet end flag.
// Depends on nothing.
interface mudp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

/* hw/rtl/mudp_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying verdict and summary fields.
// Depends on nothing.
interface mudp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] message_index;
   logic [63:0] stock_seen;
   logic        hit;
   logic        packet_hit;
   logic [31:0] packets_seen;
   logic [31:0] packets_hit;
   logic        last;

   modport source (output valid, output kind, output message_index, output stock_seen,
                   output hit, output packet_hit, output packets_seen,
                   output packets_hit, output last, input ready);
   modport sink   (input valid, input kind, input message_index, input stock_seen,
                   input hit, input packet_hit, input packets_seen,
                   input packets_hit, input last, output ready);
endinterface

/* hw/rtl/mudp_csr_if.sv */
`timescale 1ns / 1ps
// Configuration write channel: valid/ready with register index and write data.
// Depends on nothing.
interface mudp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/moldudp64_add_order_stock_filter.sv */
`timescale 1ns / 1ps
// Top level of the MoldUDP64 add order stock filter.
// Depends on mudp_pkg, the three channel interfaces, mudp_csr, mudp_parser, mudp_rsp_fifo.
//
//   channel  | dir | payload                                  | moves
//   req_ch   | in  | data_byte, end_of_packet                 | one payload byte per item
//   rsp_ch   | out | kind .. last (verdict or packet summary) | one result per item
//   csr_ch   | in  | index, data                              | one register write
//
// One byte is taken per cycle while req_ch.ready is high; its results are in the
// result queue the next cycle. A byte gives zero, one or two results; the
// four-entry queue drains one per cycle while rsp_ch.ready is high, so bytes that give
// two results are held to that rate; req_ch.ready drops while the queue holds more
// than two results. Synchronous active-high reset clears parser state, counters and
// controls, fills the stock slots with spaces; csr writes are always taken.
module moldudp64_add_order_stock_filter #(
   parameter int MAX_PACKET_BYTES = 2048,
   parameter int FILTER_SLOTS     = 6
) (
   input  logic        clock,
   input  logic        reset,
   mudp_req_if.sink    req_ch,
   mudp_rsp_if.source  rsp_ch,
   mudp_csr_if.sink    csr_ch
);

   mudp_pkg::ctrl_type            ctrl;
   logic [FILTER_SLOTS-1:0][63:0] stocks;
   mudp_pkg::push_type            push;
   mudp_pkg::rsp_item_type        out_item;
   logic                          space;
   logic                          in_fire;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = space;
   assign in_fire      = req_ch.valid && space;

   // Configuration registers
   mudp_csr #(
      .FILTER_SLOTS(FILTER_SLOTS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .ctrl     (ctrl),
      .stocks   (stocks)
   );

   // Byte parser and matcher
   mudp_parser #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
      .FILTER_SLOTS    (FILTER_SLOTS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .in_fire       (in_fire),
      .data_byte     (req_ch.data_byte),
      .end_of_packet (req_ch.end_of_packet),
      .ctrl          (ctrl),
      .stocks        (stocks),
      .push          (push)
   );

   // Result queue
   mudp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   assign rsp_ch.kind          = out_item.kind;
   assign rsp_ch.message_index = out_item.message_index;
   assign rsp_ch.stock_seen    = out_item.stock_seen;
   assign rsp_ch.hit           = out_item.hit;
   assign rsp_ch.packet_hit    = out_item.packet_hit;
   assign rsp_ch.packets_seen  = out_item.packets_seen;
   assign rsp_ch.packets_hit   = out_item.packets_hit;
   assign rsp_ch.last          = out_item.last;

endmodule

/* hw/rtl/mudp_csr.sv */
`timescale 1ns / 1ps
// Filter configuration registers: filter count, ignore flag and stock slots.
// Depends on mudp_pkg.
module mudp_csr #(
   parameter int FILTER_SLOTS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [2:0]                   wr_index,
   input  logic [63:0]                  wr_data,
   output mudp_pkg::ctrl_type           ctrl,
   output logic [FILTER_SLOTS-1:0][63:0] stocks
);

   mudp_pkg::ctrl_type                ctrl_ff;
   logic [FILTER_SLOTS-1:0][63:0]     stock_ff;

   // Scalar controls
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (wr_en) begin
         if (wr_index == mudp_pkg::REG_FILTER_COUNT) begin
            ctrl_ff.filter_count <= wr_data[2:0];
         end
         if (wr_index == mudp_pkg::REG_IGNORE_FILTER) begin
            ctrl_ff.ignore_filter <= wr_data[0];
         end
      end
   end

   // Stock slots; indexes past the implemented slots are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < FILTER_SLOTS; s++) begin
            stock_ff[s] <= mudp_pkg::SPACES8;
         end
      end else if (wr_en) begin
         for (int s = 0; s < FILTER_SLOTS; s++) begin
            if (wr_index == 3'(int'(mudp_pkg::REG_STOCK_A) + s)) begin
               stock_ff[s] <= wr_data;
            end
         end
      end
   end

   assign ctrl   = ctrl_ff;
   assign stocks = stock_ff;

endmodule

/* hw/rtl/mudp_parser.sv */
`timescale 1ns / 1ps
// Packet walker: header count, message lengths, add order stock capture and match,
// packet counters. Produces up to two result items per accepted byte. Depends on mudp_pkg.
module mudp_parser #(
   parameter int MAX_PACKET_BYTES = 2048,
   parameter int FILTER_SLOTS     = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_fire,
   input  logic [7:0]                    data_byte,
   input  logic                          end_of_packet,
   input  mudp_pkg::ctrl_type            ctrl,
   input  logic [FILTER_SLOTS-1:0][63:0] stocks,
   output mudp_pkg::push_type            push
);

   localparam int PosWidth = $clog2(MAX_PACKET_BYTES + 1);
   localparam int OW       = mudp_pkg::OffWidth;

   mudp_pkg::phase_type phase_ff, phase_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                len_sel_ff, len_sel_in;
   logic [7:0]          len_hi_ff, len_hi_in;
   logic [15:0]         msgs_left_ff, msgs_left_in;
   logic [15:0]         bytes_left_ff, bytes_left_in;
   logic [OW-1:0]       off_ff, off_in;
   logic [7:0]          type_ff, type_in;
   logic [63:0]         shift_ff, shift_in;
   logic [15:0]         msg_num_ff, msg_num_in;
   logic                flag_ff, flag_in;
   logic [31:0]         pkt_cnt_ff, pkt_cnt_in;
   logic [31:0]         hit_cnt_ff, hit_cnt_in;

   logic [15:0] count_word;
   logic [15:0] len_word;
   logic [15:0] msgs_dec;
   logic [15:0] bytes_dec;
   logic [63:0] shift_next;
   logic        match;
   logic        verdict;
   logic        finish;

   // Stock compare against configured slots; ignore flag or zero filter count matches all
   always_comb begin
      match = ctrl.ignore_filter || (ctrl.filter_count == 3'd0);
      for (int s = 0; s < FILTER_SLOTS; s++) begin
         if ((int'(ctrl.filter_count) > s) && (stocks[s] == shift_next)) begin
            match = 1'b1;
         end
      end
   end

   assign count_word = {len_hi_ff, data_byte};
   assign len_word   = {len_hi_ff, data_byte};
   assign msgs_dec   = msgs_left_ff - 16'd1;
   assign bytes_dec  = bytes_left_ff - 16'd1;
   assign shift_next = {shift_ff[55:0], data_byte};

   // Next state and result items
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      len_sel_in    = len_sel_ff;
      len_hi_in     = len_hi_ff;
      msgs_left_in  = msgs_left_ff;
      bytes_left_in = bytes_left_ff;
      off_in        = off_ff;
      type_in       = type_ff;
      shift_in      = shift_ff;
      msg_num_in    = msg_num_ff;
      flag_in       = flag_ff;
      pkt_cnt_in    = pkt_cnt_ff;
      hit_cnt_in    = hit_cnt_ff;
      verdict       = 1'b0;
      finish        = 1'b0;

      if (in_fire && (pos_ff < PosWidth'(MAX_PACKET_BYTES))) begin
         pos_in = pos_ff + PosWidth'(1);
         case (phase_ff)
            mudp_pkg::PH_HEADER: begin
               if (pos_ff == PosWidth'(mudp_pkg::HeaderBytes - 2)) begin
                  len_hi_in = data_byte;
               end else if (pos_ff == PosWidth'(mudp_pkg::HeaderBytes - 1)) begin
                  len_hi_in  = '0;
                  len_sel_in = 1'b0;
                  if (count_word == mudp_pkg::END_OF_SESSION || count_word == 16'd0) begin
                     msgs_left_in = '0;
                     phase_in     = mudp_pkg::PH_IDLE;
                  end else begin
                     msgs_left_in = count_word;
                     phase_in     = mudp_pkg::PH_LENGTH;
                  end
               end
            end
            mudp_pkg::PH_LENGTH: begin
               if (!len_sel_ff) begin
                  len_hi_in  = data_byte;
                  len_sel_in = 1'b1;
               end else begin
                  len_hi_in     = '0;
                  len_sel_in    = 1'b0;
                  bytes_left_in = len_word;
                  off_in        = '0;
                  if (len_word == 16'd0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = mudp_pkg::PH_BODY;
                  end
               end
            end
            mudp_pkg::PH_BODY: begin
               if (off_ff == '0) begin
                  type_in = data_byte;
               end
               if (off_ff >= OW'(mudp_pkg::StockOffset)
                   && off_ff < OW'(mudp_pkg::StockOffset + mudp_pkg::StockBytes)) begin
                  shift_in = shift_next;
               end
               if (off_ff == OW'(mudp_pkg::StockOffset + mudp_pkg::StockBytes - 1)
                   && type_ff == mudp_pkg::ADD_ORDER_TYPE) begin
                  verdict = 1'b1;
                  if (match) begin
                     flag_in = 1'b1;
                  end
               end
               if (off_ff != mudp_pkg::OFF_SAT) begin
                  off_in = off_ff + OW'(1);
               end
               bytes_left_in = bytes_dec;
               if (bytes_dec == 16'd0) begin
                  finish = 1'b1;
               end
            end
            default: begin
               // trailing bytes after the last message
            end
         endcase

         // message done: advance counts
         if (finish) begin
            msg_num_in    = msg_num_ff + 16'd1;
            msgs_left_in  = msgs_dec;
            off_in        = '0;
            bytes_left_in = '0;
            type_in       = '0;
            phase_in      = (msgs_dec != 16'd0) ? mudp_pkg::PH_LENGTH : mudp_pkg::PH_IDLE;
         end
      end

      // Packet end: summary counters and per-packet clear
      if (in_fire && end_of_packet) begin
         pkt_cnt_in = pkt_cnt_ff + 32'd1;
         if (flag_in) begin
            hit_cnt_in = hit_cnt_ff + 32'd1;
         end
         phase_in      = mudp_pkg::PH_HEADER;
         pos_in        = '0;
         len_sel_in    = 1'b0;
         len_hi_in     = '0;
         msgs_left_in  = '0;
         bytes_left_in = '0;
         off_in        = '0;
         type_in       = '0;
         msg_num_in    = '0;
         flag_in       = 1'b0;
      end

      // Result items
      push.vrd_valid          = verdict;
      push.vrd                = '0;
      push.vrd.kind           = mudp_pkg::KIND_VERDICT;
      push.vrd.message_index  = msg_num_ff;
      push.vrd.stock_seen     = shift_next;
      push.vrd.hit            = match;
      push.vrd.last           = !end_of_packet;

      push.sum_valid          = in_fire && end_of_packet;
      push.sum                = '0;
      push.sum.kind           = mudp_pkg::KIND_SUMMARY;
      push.sum.packet_hit     = flag_ff || (verdict && match);
      push.sum.packets_seen   = pkt_cnt_in;
      push.sum.packets_hit    = hit_cnt_in;
      push.sum.last           = 1'b1;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= mudp_pkg::PH_HEADER;
         pos_ff        <= '0;
         len_sel_ff    <= 1'b0;
         msgs_left_ff  <= '0;
         bytes_left_ff <= '0;
         off_ff        <= '0;
         msg_num_ff    <= '0;
         flag_ff       <= 1'b0;
         pkt_cnt_ff    <= '0;
         hit_cnt_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         len_sel_ff    <= len_sel_in;
         msgs_left_ff  <= msgs_left_in;
         bytes_left_ff <= bytes_left_in;
         off_ff        <= off_in;
         msg_num_ff    <= msg_num_in;
         flag_ff       <= flag_in;
         pkt_cnt_ff    <= pkt_cnt_in;
         hit_cnt_ff    <= hit_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      len_hi_ff <= len_hi_in;
      type_ff   <= type_in;
      shift_ff  <= shift_in;
   end

endmodule

/* hw/rtl/mudp_rsp_fifo.sv */
`timescale 1ns / 1ps
// Four-entry result queue: up to two items in, one out if out_ready, per cycle.
// Depends on mudp_pkg.
module mudp_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  mudp_pkg::push_type     push,
   output logic                   space,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mudp_pkg::rsp_item_type out_item
);

   mudp_pkg::rsp_item_type mem_ff [4];
   logic [1:0] wp_ff, wp_in;
   logic [1:0] rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] n_push;
   logic       pop;
   mudp_pkg::rsp_item_type e0;
   mudp_pkg::rsp_item_type e1;

   // Order the pushed items: verdict ahead of summary
   always_comb begin
      n_push = 2'(push.vrd_valid) + 2'(push.sum_valid);
      e0     = push.vrd_valid ? push.vrd : push.sum;
      e1     = push.sum;
      pop    = out_valid && out_ready;
      wp_in  = wp_ff + n_push;
      rp_in  = rp_ff + 2'(pop);
      cnt_in = cnt_ff + 3'(n_push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wp_ff] <= e0;
      end
      if (n_push == 2'd2) begin
         mem_ff[wp_ff + 2'd1] <= e1;
      end
   end

   assign space     = (cnt_ff <= 3'd2);
   assign out_valid = (cnt_ff != 3'd0);
   assign out_item  = mem_ff[rp_ff];

endmodule
